// ===== src/stcurl_pkg.sv =====
// Shared constants, types and helpers for the fourth-order curl stencil core.
// No dependencies; imported by stencil_curl_fourth_order_core.
`default_nettype none

package stcurl_pkg;

	localparam int MAX_COLS = 1024;
	localparam int MAX_ROWS = 1024;
	localparam int SAMPLE_W = 32;
	localparam int PAD      = 4;                      // ghost cells per axis, both sides
	localparam int PITCH    = MAX_COLS + PAD;         // padded row length
	localparam int ADDR_W   = $clog2(PITCH);
	localparam int POS_W    = $clog2(((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS) + PAD + 1);
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int LANES    = 4;                      // padded rows held in the line store
	localparam int LANE_W   = $clog2(LANES);
	localparam int WORD_W   = LANES * SAMPLE_W;
	localparam int SUM_W    = SAMPLE_W + 5;           // exact five-tap sum
	localparam int MAG_W    = SUM_W - 1;
	localparam int HALF_W   = MAG_W / 2;
	localparam int FAC_W    = 32;
	localparam int PP_W     = HALF_W + FAC_W;
	localparam int PROD_W   = MAG_W + FAC_W;
	localparam int FRAC_W   = 16;
	localparam int CFG_W    = 32;
	localparam int IDX_W    = 2;
	localparam int IN_W     = ((SAMPLE_W + 7) / 8) * 8;
	localparam int OUT_BITS = 2 * SAMPLE_W + ROW_W + COL_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [FAC_W-1:0] FAC_RST = FAC_W'(65536);

	typedef enum logic [IDX_W-1:0] {
		CFG_GRID_ROWS = 2'd0,
		CFG_GRID_COLS = 2'd1,
		CFG_INV_12DX  = 2'd2,
		CFG_INV_12DY  = 2'd3
	} cfg_idx_t;

	// clamp a size register to 1..hi
	function automatic logic [POS_W-1:0] clamp_size(input logic [POS_W-1:0] v,
			input logic [POS_W-1:0] hi);
		logic [POS_W-1:0] r;
		if (v == '0) begin
			r = POS_W'(1);
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// round magnitude product to nearest (ties away from zero), apply sign, saturate
	function automatic logic [SAMPLE_W-1:0] sat_q16(input logic [PROD_W-1:0] prod,
			input logic neg);
		logic [PROD_W-1:0]        rnd;
		logic [PROD_W-FRAC_W-1:0] mag;
		logic                     big;
		logic [SAMPLE_W-1:0]      r;
		rnd = prod + PROD_W'(1 << (FRAC_W - 1));
		mag = rnd[PROD_W-1:FRAC_W];
		big = |mag[PROD_W-FRAC_W-1:SAMPLE_W-1];
		if (neg) begin
			r = big ? {1'b1, {(SAMPLE_W-1){1'b0}}} : SAMPLE_W'(~mag + 1'b1);
		end else begin
			r = big ? {1'b0, {(SAMPLE_W-1){1'b1}}} : mag[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/stcurl_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// Read returns the old contents on a same-address write. No dependencies.
`default_nettype none

module stcurl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/stencil_curl_fourth_order_core.sv =====
// Fourth-order curl stencil core: top level.
// Depends on stcurl_pkg and stcurl_ram (column-word line store).
//
// Usage:
//  s_* takes the padded raster, one sample per word, row by row with two ghost
//  cells on every side (grid_cols+4 words a row, grid_rows+4 rows a frame).
//  s_tuser marks the first word of a frame. m_* gives one word for every
//  interior point in raster order: b1, b2, interior row and column; m_tlast
//  flags the final point of the frame.
//  Throughput is one sample per cycle, sustained while the output is not held.
//  The line store holds one word per padded column carrying all four buffered
//  rows; each sample reads that word in stage 0 and writes it back from stage 1
//  over a single write port, with the read-write overlap of adjacent samples
//  covered by forwarding. Point (r,c) reaches m_* once padded sample (r+4,c+4)
//  is accepted and passes the sum, magnitude, multiply and round/saturate stages.
//  Samples past the end of a frame are dropped until the next frame start.
//  When m_tready is low with a word waiting, the whole pipeline holds and
//  s_tready falls in the same cycle; nothing is lost.
//  Reset clears the position to padded (0,0), sizes to 1x1 and both factors to
//  1.0. The line store is not cleared: no unwritten lane reaches an output.
//  Configuration: cfg_we, cfg_index and cfg_data, written while idle.
`default_nettype none

module stencil_curl_fourth_order_core
	import stcurl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [IN_W-1:0]   s_tdata,   // [31:0] potential_sample
	input  wire logic [0:0]        s_tuser,   // [0] frame_start
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [OUT_W-1:0]  m_tdata,   // [31:0] field_b1, [63:32] field_b2,
	                                          // [73:64] out_row, [83:74] out_col
	output logic                   m_tlast,   // last_point
	input  wire logic              cfg_we,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data
);

	// configuration
	logic [POS_W-1:0] rows_p4_q, cols_p4_q;
	logic [FAC_W-1:0] inv_dx_q, inv_dy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_p4_q <= POS_W'(1 + PAD);
			cols_p4_q <= POS_W'(1 + PAD);
			inv_dx_q  <= FAC_RST;
			inv_dy_q  <= FAC_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_GRID_ROWS: rows_p4_q <= clamp_size(cfg_data[POS_W-1:0], POS_W'(MAX_ROWS))
						+ POS_W'(PAD);
				CFG_GRID_COLS: cols_p4_q <= clamp_size(cfg_data[POS_W-1:0], POS_W'(MAX_COLS))
						+ POS_W'(PAD);
				CFG_INV_12DX:  inv_dx_q <= cfg_data[FAC_W-1:0];
				CFG_INV_12DY:  inv_dy_q <= cfg_data[FAC_W-1:0];
			endcase
		end
	end

	// stage 0: position and line-store read
	logic                       adv, accept, ign0, emit0, last0;
	logic                       out_valid_q;
	logic [POS_W-1:0]           prow_q, pcol_q, pr0, pc0, col_nxt, rdiff0, cdiff0;
	logic signed [SAMPLE_W-1:0] sample0;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;

	always_comb begin
		sample0 = s_tdata[SAMPLE_W-1:0];
		pr0     = s_tuser[0] ? '0 : prow_q;
		pc0     = s_tuser[0] ? '0 : pcol_q;
		ign0    = (pr0 >= rows_p4_q) || (pc0 >= cols_p4_q);
		col_nxt = pc0 + POS_W'(1);
		emit0   = (pr0 >= POS_W'(PAD)) && (pc0 >= POS_W'(PAD));
		last0   = (pr0 + POS_W'(1) == rows_p4_q) && (col_nxt == cols_p4_q);
		rdiff0  = pr0 - POS_W'(PAD);
		cdiff0  = pc0 - POS_W'(PAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prow_q <= '0;
			pcol_q <= '0;
		end else if (accept) begin
			if (ign0) begin
				// park past the frame until the next frame start
				prow_q <= rows_p4_q;
				pcol_q <= pc0;
			end else if (col_nxt >= cols_p4_q) begin
				prow_q <= pr0 + POS_W'(1);
				pcol_q <= '0;
			end else begin
				prow_q <= pr0;
				pcol_q <= col_nxt;
			end
		end
	end

	logic                ram_we, ram_re;
	logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
	logic [WORD_W-1:0]   ram_wdata, ram_rdata;

	assign ram_re    = accept && !ign0;
	assign ram_raddr = pc0[ADDR_W-1:0];

	stcurl_ram #(
		.WIDTH (WORD_W),
		.DEPTH (PITCH)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// stage 1: merge sample into column word, write back, taps
	logic                       v_s1, hit_s1, emit_s1, last_s1;
	logic [WORD_W-1:0]          fwd_s1;
	logic [ADDR_W-1:0]          addr_s1;
	logic [LANE_W-1:0]          bank_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic [ROW_W-1:0]           orow_s1;
	logic [COL_W-1:0]           ocol_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			hit_s1 <= 1'b0;
		end else if (adv) begin
			v_s1   <= accept && !ign0;
			hit_s1 <= ram_we && ram_re && (ram_waddr == ram_raddr);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_s1    <= ram_wdata;
			addr_s1   <= pc0[ADDR_W-1:0];
			bank_s1   <= pr0[LANE_W-1:0];
			sample_s1 <= sample0;
			emit_s1   <= emit0;
			last_s1   <= last0;
			orow_s1   <= rdiff0[ROW_W-1:0];
			ocol_s1   <= cdiff0[COL_W-1:0];
		end
	end

	logic [WORD_W-1:0]          word1;
	logic signed [SAMPLE_W-1:0] lane1 [LANES];
	logic [LANE_W-1:0]          bk1, bk2, bk3;
	logic signed [SAMPLE_W-1:0] disp1, r1_1, r2_1, r3_1;

	always_comb begin
		word1 = hit_s1 ? fwd_s1 : ram_rdata;
		for (int k = 0; k < LANES; k++) begin
			lane1[k]                     = word1[k*SAMPLE_W +: SAMPLE_W];
			ram_wdata[k*SAMPLE_W +: SAMPLE_W] =
					(bank_s1 == LANE_W'(k)) ? sample_s1 : lane1[k];
		end
		bk1   = bank_s1 - LANE_W'(1);
		bk2   = bank_s1 - LANE_W'(2);
		bk3   = bank_s1 - LANE_W'(3);
		disp1 = lane1[bank_s1];   // row pr-4, displaced by this write
		r1_1  = lane1[bk1];
		r2_1  = lane1[bk2];
		r3_1  = lane1[bk3];
	end

	assign ram_we    = adv && v_s1;
	assign ram_waddr = addr_s1;

	// horizontal taps of row pr-2, two-deep delays of the vertical column
	logic signed [SAMPLE_W-1:0] h_q    [4];
	logic signed [SAMPLE_W-1:0] r3d_q  [2];
	logic signed [SAMPLE_W-1:0] r1d_q  [2];
	logic signed [SAMPLE_W-1:0] curd_q [2];
	logic signed [SAMPLE_W-1:0] dspd_q [2];

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			h_q[0]    <= r2_1;
			h_q[1]    <= h_q[0];
			h_q[2]    <= h_q[1];
			h_q[3]    <= h_q[2];
			r3d_q[0]  <= r3_1;
			r3d_q[1]  <= r3d_q[0];
			r1d_q[0]  <= r1_1;
			r1d_q[1]  <= r1d_q[0];
			curd_q[0] <= sample_s1;
			curd_q[1] <= curd_q[0];
			dspd_q[0] <= disp1;
			dspd_q[1] <= dspd_q[0];
		end
	end

	logic signed [SUM_W-1:0] sum1_1, sum2_1;

	always_comb begin
		sum1_1 = SUM_W'(h_q[3]) - (SUM_W'(h_q[2]) <<< 3)
				+ (SUM_W'(h_q[0]) <<< 3) - SUM_W'(r2_1);
		sum2_1 = SUM_W'(dspd_q[1]) - (SUM_W'(r3d_q[1]) <<< 3)
				+ (SUM_W'(r1d_q[1]) <<< 3) - SUM_W'(curd_q[1]);
	end

	// stage 2: sums -> magnitudes
	logic                    v_s2, last_s2;
	logic signed [SUM_W-1:0] sum1_s2, sum2_s2;
	logic [ROW_W-1:0]        orow_s2;
	logic [COL_W-1:0]        ocol_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum1_s2 <= sum1_1;
			sum2_s2 <= sum2_1;
			last_s2 <= last_s1;
			orow_s2 <= orow_s1;
			ocol_s2 <= ocol_s1;
		end
	end

	logic [SUM_W-1:0] abs1_2, abs2_2;
	logic             neg1_2, neg2_2;

	always_comb begin
		neg1_2 = sum1_s2[SUM_W-1];
		neg2_2 = !sum2_s2[SUM_W-1] && (sum2_s2 != '0);   // b2 takes the negated sum
		abs1_2 = sum1_s2[SUM_W-1] ? SUM_W'(-sum1_s2) : SUM_W'(sum1_s2);
		abs2_2 = sum2_s2[SUM_W-1] ? SUM_W'(-sum2_s2) : SUM_W'(sum2_s2);
	end

	// stage 3: split multiplies
	logic             v_s3, last_s3, neg1_s3, neg2_s3;
	logic [MAG_W-1:0] mag1_s3, mag2_s3;
	logic [ROW_W-1:0] orow_s3;
	logic [COL_W-1:0] ocol_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag1_s3 <= abs1_2[MAG_W-1:0];
			mag2_s3 <= abs2_2[MAG_W-1:0];
			neg1_s3 <= neg1_2;
			neg2_s3 <= neg2_2;
			last_s3 <= last_s2;
			orow_s3 <= orow_s2;
			ocol_s3 <= ocol_s2;
		end
	end

	logic [PP_W-1:0] p1lo_3, p1hi_3, p2lo_3, p2hi_3;

	always_comb begin
		p1lo_3 = mag1_s3[HALF_W-1:0] * inv_dy_q;
		p1hi_3 = mag1_s3[MAG_W-1:HALF_W] * inv_dy_q;
		p2lo_3 = mag2_s3[HALF_W-1:0] * inv_dx_q;
		p2hi_3 = mag2_s3[MAG_W-1:HALF_W] * inv_dx_q;
	end

	// stage 4: combine partial products, round, saturate
	logic             v_s4, last_s4, neg1_s4, neg2_s4;
	logic [PP_W-1:0]  p1lo_s4, p1hi_s4, p2lo_s4, p2hi_s4;
	logic [ROW_W-1:0] orow_s4;
	logic [COL_W-1:0] ocol_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p1lo_s4 <= p1lo_3;
			p1hi_s4 <= p1hi_3;
			p2lo_s4 <= p2lo_3;
			p2hi_s4 <= p2hi_3;
			neg1_s4 <= neg1_s3;
			neg2_s4 <= neg2_s3;
			last_s4 <= last_s3;
			orow_s4 <= orow_s3;
			ocol_s4 <= ocol_s3;
		end
	end

	logic [PROD_W-1:0]   prod1_4, prod2_4;
	logic [SAMPLE_W-1:0] b1_4, b2_4;

	always_comb begin
		prod1_4 = (PROD_W'(p1hi_s4) << HALF_W) + PROD_W'(p1lo_s4);
		prod2_4 = (PROD_W'(p2hi_s4) << HALF_W) + PROD_W'(p2lo_s4);
		b1_4    = sat_q16(prod1_4, neg1_s4);
		b2_4    = sat_q16(prod2_4, neg2_s4);
	end

	// output register
	logic [SAMPLE_W-1:0] ob1_q, ob2_q;
	logic [ROW_W-1:0]    orow_q;
	logic [COL_W-1:0]    ocol_q;
	logic                olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ob1_q   <= b1_4;
			ob2_q   <= b2_4;
			orow_q  <= orow_s4;
			ocol_q  <= ocol_s4;
			olast_q <= last_s4;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, ocol_q, orow_q, ob2_q, ob1_q};
	assign m_tlast  = olast_q;

	// checks
	a_fwd_capture: assert property (@(posedge clk) disable iff (!arst_n)
			(ram_we && ram_re && (ram_waddr == ram_raddr)) |=> hit_s1)
		else $error("same-address read/write not flagged for forwarding");

	a_fwd_owner: assert property (@(posedge clk) disable iff (!arst_n)
			hit_s1 |-> v_s1)
		else $error("forward flag set with no word in stage 1");

	a_take_in: assert property (@(posedge clk) disable iff (!arst_n)
			(accept && !ign0) |=> v_s1)
		else $error("accepted in-frame sample did not reach stage 1");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
			pcol_q < POS_W'(PITCH))
		else $error("column counter beyond line store");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
			(v_s4 && adv) |=> out_valid_q)
		else $error("result lost before output register");

endmodule

`default_nettype wire
